@@ rtl/core/grbd_pkg.sv @@
package grbd_pkg;

	// rate fraction bits; the scaling shift follows from it
	localparam int FRAC_BITS = 8;
	localparam int SCALE_SH  = 16 - FRAC_BITS;

	localparam int RAW_W   = 16;
	localparam int SCL_W   = 16;
	localparam int PROD_W  = RAW_W + SCL_W + 1;
	localparam int RATE_W  = 20;
	localparam int SUM_W   = 40;
	localparam int FILT_W  = 28;
	localparam int CNT_W   = 16;
	localparam int TIME_W  = 32;
	localparam int MAXR_W  = 19;
	localparam int ALPHA_W = 9;
	localparam int STEP_W  = $clog2(SUM_W + 1);

	localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [ALPHA_W-1:0]       ALPHA_ONE = 9'd256;

	typedef enum logic [2:0] {
		CFG_SCALE,
		CFG_NEGATE,
		CFG_MAX_RATE,
		CFG_DEADBAND,
		CFG_ALPHA,
		CFG_WINDOW,
		CFG_MIN_COUNT
	} cfg_idx_t;

	typedef struct packed {
		logic [SCL_W-1:0]   scale_q16;
		logic               negate_axis;
		logic [MAXR_W-1:0]  max_rate;
		logic [15:0]        deadband;
		logic [ALPHA_W-1:0] alpha_q8;
		logic [15:0]        window_ms;
		logic [CNT_W-1:0]   min_count;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic scale;
		logic restart;
		logic accum;
		logic div_start;
		logic cal_finish;
		logic corr;
		logic fmul;
		logic fadd;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic restart;
		logic calibrated;
		logic cal_ready;
		logic div_done;
	} dp_sts_t;

endpackage

@@ rtl/core/grbd_div.sv @@
module grbd_div
	import grbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    rem_sh;
	logic              ge;
	logic [CNT_W:0]    rem_sub;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, quo_q[SUM_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/grbd_datapath.sv @@
module grbd_datapath
	import grbd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	input  logic                     action,
	input  logic signed [RAW_W-1:0]  raw_rate,
	input  logic [TIME_W-1:0]        time_ms,
	output logic signed [RATE_W-1:0] rate_out,
	output logic                     valid_res,
	output logic                     calibrating,
	output logic                     stationary,
	output logic [15:0]              sequence_res,
	output logic [TIME_W-1:0]        stamp_ms
);

	localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) <<< (SCALE_SH - 1);

	// item registers
	logic                      action_q;
	logic signed [RAW_W-1:0]   raw_q;
	logic [TIME_W-1:0]         time_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [RATE_W-1:0]  scaled_q;
	logic signed [RATE_W-1:0]  corr_q;
	logic signed [38:0]        fprod_q;
	logic                      res_valid_q;
	logic                      res_stat_q;

	// architectural state
	logic                      is_cal_q;
	logic [TIME_W-1:0]         wstart_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [RATE_W-1:0]  bias_q;
	logic signed [FILT_W-1:0]  filt_q;
	logic [15:0]               seq_q;
	logic [TIME_W-1:0]         stamp_q;

	// output register
	logic signed [RATE_W-1:0]  rate_out_q;
	logic                      valid_out_q;
	logic                      calib_out_q;
	logic                      stat_out_q;
	logic [15:0]               seq_out_q;
	logic [TIME_W-1:0]         stamp_out_q;

	logic signed [PROD_W:0]    rnd;
	logic signed [PROD_W:0]    shr;
	logic signed [PROD_W+1:0]  sneg;
	logic signed [RATE_W-1:0]  scaled_d;
	logic signed [SUM_W:0]     sum_wide;
	logic signed [SUM_W-1:0]   sum_d;
	logic [CNT_W-1:0]          count_d;
	logic [TIME_W-1:0]         elapsed;
	logic [CNT_W-1:0]          need;
	logic                      sum_neg;
	logic [SUM_W-1:0]          sum_mag;
	logic [SUM_W-1:0]          quot;
	logic                      div_done;
	logic signed [RATE_W-1:0]  bias_d;
	logic signed [RATE_W:0]    diff;
	logic signed [RATE_W:0]    lim;
	logic signed [RATE_W:0]    nlim;
	logic signed [RATE_W-1:0]  corr_d;
	logic [RATE_W-1:0]         corr_abs;
	logic                      stat_d;
	logic [ALPHA_W-1:0]        alpha;
	logic signed [FILT_W:0]    fdiff;
	logic signed [38:0]        fstep;
	logic signed [38:0]        fsum;
	logic signed [FILT_W:0]    frnd;

	always_comb begin
		// scaling with round half up, floor shift, sign flip, saturation
		rnd  = (PROD_W+1)'(prod_q) + ROUND_HALF;
		shr  = rnd >>> SCALE_SH;
		sneg = cfg.negate_axis ? -((PROD_W+2)'(shr)) : (PROD_W+2)'(shr);
		if (sneg > (PROD_W+2)'(RATE_MAX)) begin
			scaled_d = RATE_MAX;
		end else if (sneg < (PROD_W+2)'(RATE_MIN)) begin
			scaled_d = RATE_MIN;
		end else begin
			scaled_d = sneg[RATE_W-1:0];
		end

		// calibration sum and count
		sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(scaled_q);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_d = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_d = sum_wide[SUM_W-1:0];
		end
		count_d = (count_q != '1) ? count_q + 1'b1 : count_q;
		elapsed = time_q - wstart_q;
		need    = (cfg.min_count == '0) ? CNT_W'(1) : cfg.min_count;

		// bias from magnitude quotient
		sum_neg = sum_q[SUM_W-1];
		sum_mag = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		if (sum_neg) begin
			if (quot > SUM_W'(-(SUM_W+1)'(RATE_MIN))) begin
				bias_d = RATE_MIN;
			end else begin
				bias_d = -$signed(quot[RATE_W-1:0]);
			end
		end else begin
			if (quot > SUM_W'(RATE_MAX)) begin
				bias_d = RATE_MAX;
			end else begin
				bias_d = $signed(quot[RATE_W-1:0]);
			end
		end

		// bias removal, clamp and deadband
		diff = (RATE_W+1)'(scaled_q) - (RATE_W+1)'(bias_q);
		lim  = $signed({2'b00, cfg.max_rate});
		nlim = -lim;
		if (diff > lim) begin
			corr_d = lim[RATE_W-1:0];
		end else if (diff < nlim) begin
			corr_d = nlim[RATE_W-1:0];
		end else begin
			corr_d = diff[RATE_W-1:0];
		end
		corr_abs = corr_d[RATE_W-1] ? RATE_W'(-corr_d) : RATE_W'(corr_d);
		stat_d   = corr_abs < RATE_W'(cfg.deadband);

		// exponential filter
		alpha = (cfg.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q8;
		fdiff = ((FILT_W+1)'(corr_q) <<< 8) - (FILT_W+1)'(filt_q);
		fstep = fprod_q >>> 8;
		fsum  = 39'(filt_q) + fstep;
		frnd  = (FILT_W+1)'(filt_q) + (FILT_W+1)'(128);
	end

	grbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q    <= action;
			raw_q       <= raw_rate;
			time_q      <= time_ms;
			res_valid_q <= 1'b0;
			res_stat_q  <= 1'b0;
		end
		if (cmd.mul) begin
			prod_q <= raw_q * $signed({1'b0, cfg.scale_q16});
		end
		if (cmd.scale) begin
			scaled_q <= scaled_d;
		end
		if (cmd.corr) begin
			corr_q     <= corr_d;
			res_stat_q <= stat_d;
		end
		if (cmd.fmul) begin
			fprod_q <= $signed({1'b0, alpha}) * fdiff;
		end
		if (cmd.fadd || cmd.cal_finish) begin
			res_valid_q <= 1'b1;
		end
		if (cmd.emit) begin
			rate_out_q  <= (res_valid_q && !res_stat_q) ? frnd[FILT_W-1:8] : '0;
			valid_out_q <= res_valid_q;
			calib_out_q <= !is_cal_q;
			stat_out_q  <= res_stat_q;
			seq_out_q   <= seq_q;
			stamp_out_q <= stamp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_cal_q <= 1'b0;
			wstart_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			bias_q   <= '0;
			filt_q   <= '0;
			seq_q    <= '0;
			stamp_q  <= '0;
		end else begin
			if (cmd.restart) begin
				is_cal_q <= 1'b0;
				wstart_q <= time_q;
				count_q  <= '0;
				sum_q    <= '0;
				bias_q   <= '0;
				filt_q   <= '0;
			end
			if (cmd.accum) begin
				sum_q   <= sum_d;
				count_q <= count_d;
			end
			if (cmd.cal_finish) begin
				bias_q   <= bias_d;
				filt_q   <= '0;
				is_cal_q <= 1'b1;
			end
			if (cmd.fadd) begin
				filt_q <= fsum[FILT_W-1:0];
			end
			if (cmd.fadd || cmd.cal_finish) begin
				seq_q   <= seq_q + 1'b1;
				stamp_q <= time_q;
			end
		end
	end

	assign sts.restart    = action_q;
	assign sts.calibrated = is_cal_q;
	assign sts.cal_ready  = (elapsed >= TIME_W'(cfg.window_ms)) && (count_q >= need);
	assign sts.div_done   = div_done;

	assign rate_out     = rate_out_q;
	assign valid_res    = valid_out_q;
	assign calibrating  = calib_out_q;
	assign stationary   = stat_out_q;
	assign sequence_res = seq_out_q;
	assign stamp_ms     = stamp_out_q;

endmodule

@@ rtl/core/grbd_ctrl.sv @@
module grbd_ctrl
	import grbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_BRANCH,
		ST_CHECK,
		ST_DIV,
		ST_FMUL,
		ST_FADD,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				if (sts.restart) begin
					cmd.restart = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_BRANCH;
			end
			ST_BRANCH: begin
				if (sts.calibrated) begin
					cmd.corr = 1'b1;
					state_d  = ST_FMUL;
				end else begin
					cmd.accum = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.cal_ready) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.cal_finish = 1'b1;
					state_d        = ST_EMIT;
				end
			end
			ST_FMUL: begin
				cmd.fmul = 1'b1;
				state_d  = ST_FADD;
			end
			ST_FADD: begin
				cmd.fadd = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/gyro_rate_bias_deadband_filter.sv @@
// channel   | handshake            | payload
// in        | in_valid / in_ready   | action, raw_rate, time_ms
// out       | out_valid / out_ready | rate_out, valid_res, calibrating, stationary,
//           |                       | sequence_res, stamp_ms
// cfg       | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// restart item: load, emit; sample: load, multiply, scale, then accumulate or filter, emit
// the calibration-finishing sample also waits for the 40-step serial divider
// one item at a time; the next is taken once the result sits in the output register
// a stalled output holds the result and keeps the controller waiting for a free slot
// reset clears calibration, filter, sequence and timestamp state; cfg_ready is always high
module gyro_rate_bias_deadband_filter
	import grbd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     action,
	input  logic signed [RAW_W-1:0]  raw_rate,
	input  logic [TIME_W-1:0]        time_ms,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [RATE_W-1:0] rate_out,
	output logic                     valid_res,
	output logic                     calibrating,
	output logic                     stationary,
	output logic [15:0]              sequence_res,
	output logic [TIME_W-1:0]        stamp_ms,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [MAXR_W-1:0]        cfg_data
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_q16   <= 16'd1001;
			cfg_q.negate_axis <= 1'b0;
			cfg_q.max_rate    <= 19'd128000;
			cfg_q.deadband    <= 16'd128;
			cfg_q.alpha_q8    <= 9'd64;
			cfg_q.window_ms   <= 16'd1000;
			cfg_q.min_count   <= 16'd100;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCALE:     cfg_q.scale_q16   <= cfg_data[SCL_W-1:0];
				CFG_NEGATE:    cfg_q.negate_axis <= cfg_data[0];
				CFG_MAX_RATE:  cfg_q.max_rate    <= cfg_data;
				CFG_DEADBAND:  cfg_q.deadband    <= cfg_data[15:0];
				CFG_ALPHA:     cfg_q.alpha_q8    <= cfg_data[ALPHA_W-1:0];
				CFG_WINDOW:    cfg_q.window_ms   <= cfg_data[15:0];
				CFG_MIN_COUNT: cfg_q.min_count   <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	grbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	grbd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.raw_rate     (raw_rate),
		.time_ms      (time_ms),
		.rate_out     (rate_out),
		.valid_res    (valid_res),
		.calibrating  (calibrating),
		.stationary   (stationary),
		.sequence_res (sequence_res),
		.stamp_ms     (stamp_ms)
	);

endmodule

@@ tb/sv/gyro_rate_bias_deadband_filter_tb.sv @@
`timescale 1ns / 100ps

module gyro_rate_bias_deadband_filter_tb
	import grbd_pkg::*;
();

	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	localparam int RANDOM_ITEMS = 1450;
	localparam int OPEN_RUN     = 40;
	localparam int TAIL_CYCLES  = 60;
	localparam int TIMEOUT_NS   = 20_000_000;

	localparam longint RATE_HI = longint'(RATE_MAX);
	localparam longint RATE_LO = longint'(RATE_MIN);
	localparam longint SUM_HI  = longint'(SUM_MAX);
	localparam longint SUM_LO  = longint'(SUM_MIN);

	typedef enum {OP_ITEM, OP_WRITE, OP_DRAIN} op_kind_t;
	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct {
		op_kind_t          kind;
		logic              act;
		logic signed [15:0] raw;
		logic [31:0]       stamp;
		cfg_idx_t          idx;
		logic [18:0]       data;
	} op_t;

	typedef struct packed {
		logic signed [RATE_W-1:0] rate;
		logic                     valid;
		logic                     cal;
		logic                     stat;
		logic [15:0]              seq;
		logic [TIME_W-1:0]        stamp;
	} rate_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     action = ACT_SAMPLE;
	logic signed [RAW_W-1:0]  raw_rate = '0;
	logic [TIME_W-1:0]        time_ms = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [RATE_W-1:0] rate_out;
	logic                     valid_res;
	logic                     calibrating;
	logic                     stationary;
	logic [15:0]              sequence_res;
	logic [TIME_W-1:0]        stamp_ms;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [2:0]               cfg_index = '0;
	logic [MAXR_W-1:0]        cfg_data = '0;

	gyro_rate_bias_deadband_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.raw_rate     (raw_rate),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rate_out     (rate_out),
		.valid_res    (valid_res),
		.calibrating  (calibrating),
		.stationary   (stationary),
		.sequence_res (sequence_res),
		.stamp_ms     (stamp_ms),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	op_t          pending[$];
	rate_result_t rates_due[$];
	int           mismatches = 0;
	int           items_queued = 0;

	// conditioner copy: settings
	logic [15:0]  m_scale;
	logic         m_negate;
	logic [18:0]  m_max_rate;
	logic [15:0]  m_deadband;
	logic [8:0]   m_alpha;
	logic [15:0]  m_window;
	logic [15:0]  m_min_count;

	// conditioner copy: state
	logic         calibrated;
	logic [31:0]  window_start;
	logic [15:0]  sample_cnt;
	longint       acc_sum;
	longint       bias_est;
	longint       filt;
	logic [15:0]  pub_cnt;
	logic [31:0]  pub_stamp;

	// driver and monitor state
	bit           in_hold, cfg_hold, next_in, next_cfg;
	int           burst_left, gap_left;
	op_t          head;
	rate_result_t want;
	rx_mode_t     stall_mode;
	int           mode_left;
	int unsigned  stall_tick;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int jitter(input int span);
		int v;
		v = $urandom_range(0, 2 * span);
		return v - span;
	endfunction

	function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(0, 4))
		0: return lo;
		1: return hi;
		default: return $urandom_range(lo, hi);
		endcase
	endfunction

	function automatic void restart_calibration(input logic [31:0] now);
		calibrated = 1'b0;
		window_start = now;
		sample_cnt = '0;
		acc_sum = 0;
		bias_est = 0;
		filt = 0;
	endfunction

	function automatic rate_result_t condition_sample(input logic act,
			input logic signed [15:0] raw, input logic [31:0] now);
		rate_result_t r;
		longint scaled, corr, lim, a;
		logic [15:0] need;
		logic [31:0] elapsed;
		r = '0;
		if (act == ACT_RESTART) begin
			restart_calibration(now);
		end else begin
			scaled = (longint'(raw) * longint'(m_scale) + (longint'(1) << (SCALE_SH - 1)))
				>>> SCALE_SH;
			if (m_negate)
				scaled = -scaled;
			scaled = clip(scaled, RATE_LO, RATE_HI);
			if (!calibrated) begin
				need = (m_min_count == 16'd0) ? 16'd1 : m_min_count;
				acc_sum = clip(acc_sum + scaled, SUM_LO, SUM_HI);
				if (sample_cnt != 16'hFFFF)
					sample_cnt++;
				elapsed = now - window_start;
				if (elapsed >= m_window && sample_cnt >= need) begin
					bias_est = clip(acc_sum / longint'(sample_cnt), RATE_LO, RATE_HI);
					filt = 0;
					calibrated = 1'b1;
					r.valid = 1'b1;
				end
			end else begin
				lim = longint'(m_max_rate);
				corr = clip(scaled - bias_est, -lim, lim);
				r.stat = (((corr < 0) ? -corr : corr) < longint'(m_deadband));
				a = (m_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(m_alpha);
				filt = filt + ((a * (corr * 256 - filt)) >>> 8);
				r.rate = r.stat ? '0 : RATE_W'((filt + 128) >>> 8);
				r.valid = 1'b1;
			end
			if (r.valid) begin
				pub_cnt++;
				pub_stamp = now;
			end
		end
		r.cal = !calibrated;
		r.seq = pub_cnt;
		r.stamp = pub_stamp;
		return r;
	endfunction

	task automatic push_item(input logic act, input int raw, input logic [31:0] t);
		op_t o;
		o.kind = OP_ITEM;
		o.act = act;
		o.raw = 16'(clip(raw, -32768, 32767));
		o.stamp = t;
		o.idx = CFG_SCALE;
		o.data = '0;
		pending.push_back(o);
		items_queued++;
	endtask

	task automatic push_write(input cfg_idx_t idx, input int unsigned val);
		op_t o;
		o.kind = OP_WRITE;
		o.act = ACT_SAMPLE;
		o.raw = '0;
		o.stamp = '0;
		o.idx = idx;
		o.data = val[18:0];
		pending.push_back(o);
	endtask

	task automatic push_drain();
		op_t o;
		o.kind = OP_DRAIN;
		o.act = ACT_SAMPLE;
		o.raw = '0;
		o.stamp = '0;
		o.idx = CFG_SCALE;
		o.data = '0;
		pending.push_back(o);
	endtask

	task automatic check_field(input string name, input logic signed [63:0] exp_v,
			input logic signed [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("gyro_rate_bias_deadband_filter_tb: errors");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			action <= ACT_SAMPLE;
			raw_rate <= '0;
			time_ms <= '0;
			cfg_index <= CFG_SCALE;
			cfg_data <= '0;
			m_scale = 16'd1001;
			m_negate = 1'b0;
			m_max_rate = 19'd128000;
			m_deadband = 16'd128;
			m_alpha = 9'd64;
			m_window = 16'd1000;
			m_min_count = 16'd100;
			restart_calibration('0);
			pub_cnt = '0;
			pub_stamp = '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			in_hold = in_valid && !in_ready;
			cfg_hold = cfg_valid && !cfg_ready;
			if (in_valid && in_ready) begin
				rates_due.push_back(condition_sample(action, raw_rate, time_ms));
				pending.delete(0);
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_SCALE:     m_scale = cfg_data[15:0];
				CFG_NEGATE:    m_negate = cfg_data[0];
				CFG_MAX_RATE:  m_max_rate = cfg_data;
				CFG_DEADBAND:  m_deadband = cfg_data[15:0];
				CFG_ALPHA:     m_alpha = cfg_data[8:0];
				CFG_WINDOW:    m_window = cfg_data[15:0];
				CFG_MIN_COUNT: m_min_count = cfg_data[15:0];
				default: ;
				endcase
				pending.delete(0);
			end
			next_in = in_hold;
			next_cfg = cfg_hold;
			if (!in_hold && !cfg_hold && pending.size() != 0) begin
				head = pending[0];
				case (head.kind)
				OP_ITEM: begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						next_in = 1'b1;
						action <= head.act;
						raw_rate <= head.raw;
						time_ms <= head.stamp;
					end
				end
				OP_WRITE: begin
					// settings change only with nothing in flight
					if (rates_due.size() == 0) begin
						next_cfg = 1'b1;
						cfg_index <= head.idx;
						cfg_data <= head.data;
					end
				end
				default: begin
					if (rates_due.size() == 0)
						pending.delete(0);
				end
				endcase
			end
			in_valid <= next_in;
			cfg_valid <= next_cfg;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode = RX_FREE;
			mode_left = 0;
			stall_tick = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rates_due.size() == 0) begin
					$error("result transfer with no expectation pending");
					mismatches++;
				end else begin
					want = rates_due.pop_front();
					check_field("rate_out", $signed(want.rate), rate_out);
					check_field("valid_res", want.valid, valid_res);
					check_field("calibrating", want.cal, calibrating);
					check_field("stationary", want.stat, stationary);
					check_field("sequence_res", want.seq, sequence_res);
					check_field("stamp_ms", want.stamp, stamp_ms);
				end
			end
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 400);
			end else begin
				mode_left--;
			end
			stall_tick++;
			case (stall_mode)
			RX_FREE:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= ((stall_tick % 8) < 5);
			endcase
		end
	end

	// stimulus and end of run
	initial begin
		int win, mc, need, k, step, m, pick, base, n, start_items;
		logic [31:0] t;

		// first sample calibrates at once, then extremes of the raw range
		push_write(CFG_WINDOW, 0);
		push_write(CFG_MIN_COUNT, 1);
		push_item(ACT_SAMPLE, 0, 32'd10);
		push_item(ACT_SAMPLE, 32767, 32'd11);
		push_item(ACT_SAMPLE, -32768, 32'd12);
		push_item(ACT_SAMPLE, 1, 32'd13);
		push_item(ACT_SAMPLE, -1, 32'd14);
		push_item(ACT_SAMPLE, 100, 32'd15);
		push_item(ACT_SAMPLE, 30, 32'd16);
		push_item(ACT_SAMPLE, 0, 32'd17);
		push_item(ACT_RESTART, -32768, 32'hFFFF_FFF0);

		// window elapses across the timestamp wrap
		push_write(CFG_WINDOW, 40);
		push_write(CFG_MIN_COUNT, 3);
		push_item(ACT_SAMPLE, 32767, 32'hFFFF_FFF8);
		push_item(ACT_SAMPLE, -32768, 32'h0000_0005);
		push_item(ACT_SAMPLE, 5, 32'h0000_0010);
		push_item(ACT_SAMPLE, 7, 32'h0000_0020);
		push_item(ACT_SAMPLE, 7, 32'h0000_0021);

		// zero clamp, then zero deadband
		push_write(CFG_MAX_RATE, 0);
		push_item(ACT_SAMPLE, 32767, 32'h0000_0022);
		push_write(CFG_DEADBAND, 0);
		push_item(ACT_SAMPLE, 0, 32'h0000_0023);

		// full scale with sign flip saturates both ways
		push_write(CFG_MAX_RATE, 524287);
		push_write(CFG_ALPHA, 256);
		push_write(CFG_NEGATE, 1);
		push_write(CFG_SCALE, 65535);
		push_item(ACT_SAMPLE, 32767, 32'h0000_0024);
		push_item(ACT_SAMPLE, -32768, 32'h0000_0025);

		// zero weight holds the filter, oversized weight acts as one
		push_write(CFG_ALPHA, 0);
		push_item(ACT_SAMPLE, 1000, 32'h0000_0026);
		push_write(CFG_ALPHA, 511);
		push_item(ACT_SAMPLE, -1000, 32'h0000_0027);

		// zero minimum count acts as one
		push_write(CFG_MIN_COUNT, 0);
		push_write(CFG_WINDOW, 0);
		push_item(ACT_RESTART, 12345, 32'h0000_0030);
		push_item(ACT_SAMPLE, 3, 32'h0000_0031);

		// long window and high minimum keep calibration open
		push_write(CFG_NEGATE, 0);
		push_write(CFG_WINDOW, 65535);
		push_write(CFG_MIN_COUNT, 65535);
		push_write(CFG_ALPHA, 64);
		push_write(CFG_DEADBAND, 128);
		t = 32'h8000_0000;
		push_item(ACT_RESTART, 0, t);
		for (int i = 0; i < OPEN_RUN; i++)
			push_item(ACT_SAMPLE, jitter(32767), t);
		push_item(ACT_SAMPLE, 0, t + 32'd65535);
		for (int i = 1; i <= 5; i++)
			push_item(ACT_SAMPLE, jitter(32767), t + 32'd65535 + i);

		start_items = items_queued;
		while (items_queued - start_items < RANDOM_ITEMS) begin
			win = ($urandom_range(0, 7) == 0) ? pick_value(0, 65535) : $urandom_range(0, 60);
			mc = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
			if ($urandom_range(0, 3) == 0)
				push_drain();
			push_write(CFG_SCALE, pick_value(1, 65535));
			push_write(CFG_NEGATE, $urandom_range(0, 1));
			push_write(CFG_MAX_RATE, pick_value(0, 524287));
			push_write(CFG_DEADBAND,
				($urandom_range(0, 1) == 1) ? pick_value(0, 65535) : $urandom_range(0, 3000));
			push_write(CFG_ALPHA,
				($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) : pick_value(0, 256));
			push_write(CFG_WINDOW, win);
			push_write(CFG_MIN_COUNT, mc);

			need = (mc == 0) ? 1 : mc;
			k = need + $urandom_range(0, 3);
			step = (win + k - 1) / k + $urandom_range(0, 2);
			base = ($urandom_range(0, 3) == 0) ? jitter(32767) : jitter(400);
			t = $urandom;
			if ($urandom_range(0, 7) != 0)
				push_item(ACT_RESTART, jitter(32767), t);
			for (int i = 0; i < k; i++) begin
				t = t + step;
				push_item(ACT_SAMPLE, base + jitter(3), t);
			end

			m = $urandom_range(16, 48);
			for (int j = 0; j < m; j++) begin
				pick = $urandom_range(0, 19);
				t = ($urandom_range(0, 29) == 0) ? $urandom : t + $urandom_range(0, 20);
				if (pick == 0) begin
					push_item(ACT_RESTART, jitter(32767), t);
				end else begin
					case (pick)
					1, 2: n = jitter(32767);
					3: n = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
					4, 5, 6, 7, 8, 9: n = base + jitter(3);
					default: n = base + jitter(1500);
					endcase
					push_item(ACT_SAMPLE, n, t);
				end
				if (j == m / 2 && $urandom_range(0, 3) == 0)
					push_drain();
			end
		end

		while (pending.size() != 0 || rates_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("gyro_rate_bias_deadband_filter_tb: clean");
		else
			$display("gyro_rate_bias_deadband_filter_tb: errors");
		$finish;
	end

endmodule
